// File: hdl/tshc_pkg.sv
// package for the tar stream header checker
// shared constants and codes; no dependencies
`default_nettype none
package tshc_pkg;
    localparam int BLOCK_BYTES = 512;
    localparam int OFS_W       = $clog2(BLOCK_BYTES);

    localparam logic [2:0] PH_HEADER  = 3'd0;
    localparam logic [2:0] PH_PAYLOAD = 3'd1;
    localparam logic [2:0] PH_SKIP    = 3'd2;
    localparam logic [2:0] PH_PAD     = 3'd3;
    localparam logic [2:0] PH_DONE    = 3'd4;
    localparam logic [2:0] PH_ERROR   = 3'd5;

    localparam logic [1:0] OCT_SKIP = 2'd0;
    localparam logic [1:0] OCT_DIG  = 2'd1;
    localparam logic [1:0] OCT_DONE = 2'd2;
    localparam logic [1:0] OCT_FAIL = 2'd3;

    localparam logic [1:0] KIND_VERDICT = 2'd0;
    localparam logic [1:0] KIND_PAYLOAD = 2'd1;
    localparam logic [1:0] KIND_END     = 2'd2;

    localparam logic [3:0] ST_OK        = 4'd0;
    localparam logic [3:0] ST_CHECKSUM  = 4'd1;
    localparam logic [3:0] ST_NAME      = 4'd2;
    localparam logic [3:0] ST_SIZEMODE  = 4'd3;
    localparam logic [3:0] ST_AFTERLINK = 4'd4;
    localparam logic [3:0] ST_LINKDATA  = 4'd5;
    localparam logic [3:0] ST_LINKEMPTY = 4'd6;
    localparam logic [3:0] ST_TYPE      = 4'd7;
    localparam logic [3:0] ST_TRUNC     = 4'd8;
    localparam logic [3:0] ST_NOMEMBERS = 4'd9;

    localparam logic [1:0] MT_REG  = 2'd0;
    localparam logic [1:0] MT_DIR  = 2'd1;
    localparam logic [1:0] MT_LINK = 2'd2;

    typedef struct packed {
        logic [1:0]  kind;
        logic [3:0]  status;
        logic [1:0]  mtype;
        logic [35:0] size;
        logic [11:0] mode;
        logic [7:0]  pbyte;
        logic        last;
    } result_t;
endpackage
`default_nettype wire

// File: hdl/tar_stream_header_checker.sv
// tar stream header checker, top level
// uses tshc_pkg for codes and the result type
//
// channel  dir  beat contents (low bit first)
// s_axis   in   tdata[7:0] data_byte, tuser stream_end
// m_axis   out  tdata[63:0] status, member_type, member_size, member_mode,
//                payload_byte (zero fill to 64), tuser result_kind,
//                tlast last_of_member
//
// one byte per cycle while s_axis_tready is high: a beat is parsed in the cycle
// it is accepted and its result lands in a one-deep output register; the input
// register is the parse state itself
// a new beat is taken whenever the output register is empty or being drained
// asynchronous active-low reset returns to the start of a header block
`default_nettype none
module tar_stream_header_checker
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // data_byte
    input  wire logic        s_axis_tuser,   // stream_end
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [63:0]      m_axis_tdata,   // status, member_type, member_size,
                                             // member_mode, payload_byte
    output logic [1:0]       m_axis_tuser,   // result_kind
    output logic             m_axis_tlast    // last_of_member
);
    import tshc_pkg::*;

    logic [OFS_W-1:0] ofs_reg, ofs_next;
    logic [2:0]       phase_reg, phase_next;
    logic [16:0]      sum_reg, sum_next;
    logic             zero_reg, zero_next;
    logic [35:0]      size_reg, size_next;
    logic [23:0]      mode_reg, mode_next;
    logic [23:0]      chk_reg, chk_next;
    logic [5:0]       oct_reg, oct_next;
    logic [7:0]       type_reg, type_next;
    logic [7:0]       flg_reg, flg_next;
    logic [35:0]      rem_reg, rem_next;
    logic [OFS_W-1:0] pad_reg, pad_next;
    logic             link_reg, link_next;
    logic             memb_reg, memb_next;
    logic             lnk_ne_reg, lnk_ne_next;
    logic             ov_reg, ov_next;
    result_t          res_reg, res_next;
    logic             emit;
    logic             take;

    assign s_axis_tready = !ov_reg || m_axis_tready;
    assign take = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = ov_reg;
    assign m_axis_tuser  = res_reg.kind;
    assign m_axis_tlast  = res_reg.last;
    assign m_axis_tdata  = {2'b00, res_reg.pbyte, res_reg.mode, res_reg.size,
                            res_reg.mtype, res_reg.status};

    // octal digit feed for one field, returns {state, new accumulator}
    function automatic logic [37:0] oct_feed(input logic [1:0] st, input logic [7:0] c,
                                             input logic [35:0] acc);
        logic       blank;
        logic [1:0] s;
        logic [35:0] a;
        blank = (c == 8'd0) || (c == 8'd32);
        s = st;
        a = acc;
        if (!(st == OCT_SKIP && blank) && (st == OCT_SKIP || st == OCT_DIG)) begin
            if (blank)
                s = OCT_DONE;
            else if (c < 8'd48 || c > 8'd55)
                s = OCT_FAIL;
            else begin
                s = OCT_DIG;
                a = {acc[32:0], c[2:0]};
            end
        end
        return {s, a};
    endfunction

    // path component tracker; flags: 0 empty, 1 slash, 2 dotdot, 4:3 comp,
    // 5 term, 6 prefix nonempty, 7 prefix slash
    function automatic logic [7:0] path_feed(input logic [7:0] fin, input logic [7:0] c,
                                             input logic fl_last);
        logic [7:0] f;
        logic [1:0] comp;
        f = fin;
        comp = fin[4:3];
        if (!fin[5]) begin
            if (c == 8'd0) begin
                if (comp == 2'd2) f[2] = 1'b1;
                f[5] = 1'b1;
                comp = 2'd0;
            end else if (c == 8'd47) begin
                if (comp == 2'd2) f[2] = 1'b1;
                comp = 2'd0;
            end else if (c == 8'd46 && comp < 2'd2)
                comp = comp + 2'd1;
            else
                comp = 2'd3;
            if (fl_last && !f[5] && comp == 2'd2) f[2] = 1'b1;
            f[4:3] = comp;
        end
        return f;
    endfunction

    always_comb
    begin
        logic [7:0]  b;
        logic [9:0]  o;
        logic [37:0] r;
        logic        bad_name;
        logic [7:0]  t;
        logic [3:0]  st;
        logic [1:0]  mt;
        logic [35:0] rm1;
        b = s_axis_tdata;
        o = {1'b0, ofs_reg};
        r = '0;
        bad_name = 1'b0;
        t = '0;
        st = ST_OK;
        mt = MT_REG;
        rm1 = rem_reg - 36'd1;
        ofs_next = ofs_reg; phase_next = phase_reg; sum_next = sum_reg;
        zero_next = zero_reg; size_next = size_reg; mode_next = mode_reg;
        chk_next = chk_reg; oct_next = oct_reg; type_next = type_reg;
        flg_next = flg_reg; rem_next = rem_reg; pad_next = pad_reg;
        link_next = link_reg; memb_next = memb_reg; lnk_ne_next = lnk_ne_reg;
        ov_next = ov_reg && !m_axis_tready;
        res_next = res_reg;
        emit = 1'b0;
        if (take && phase_reg != PH_DONE && phase_reg != PH_ERROR) begin
            res_next = '0;
            if (s_axis_tuser) begin
                emit = 1'b1;
                res_next.kind = KIND_END;
                if (phase_reg == PH_HEADER && ofs_reg == '0) begin
                    phase_next = PH_DONE;
                    res_next.status = memb_reg ? ST_OK : ST_NOMEMBERS;
                end else begin
                    phase_next = PH_ERROR;
                    res_next.status = ST_TRUNC;
                end
            end else begin
                case (phase_reg)
                    PH_HEADER:
                    begin
                        if (o == 10'd0) begin
                            sum_next = '0; zero_next = 1'b1; size_next = '0;
                            mode_next = '0; chk_next = '0; oct_next = '0;
                            type_next = '0; lnk_ne_next = 1'b0;
                            flg_next = {6'd0, b == 8'd47, b == 8'd0};
                        end
                        sum_next = sum_next + ((o >= 10'd148 && o < 10'd156) ? 17'd32
                                                                           : {9'd0, b});
                        if (b != 8'd0) zero_next = 1'b0;
                        if (o >= 10'd100 && o < 10'd108) begin
                            r = oct_feed(oct_next[1:0], b, {12'd0, mode_next});
                            oct_next[1:0] = r[37:36];
                            mode_next = r[23:0];
                        end
                        if (o >= 10'd124 && o < 10'd136) begin
                            r = oct_feed(oct_next[3:2], b, size_next);
                            oct_next[3:2] = r[37:36];
                            size_next = r[35:0];
                        end
                        if (o >= 10'd148 && o < 10'd156) begin
                            r = oct_feed(oct_next[5:4], b, {12'd0, chk_next});
                            oct_next[5:4] = r[37:36];
                            chk_next = r[23:0];
                        end
                        if (o == 10'd156) type_next = b;
                        if (o == 10'd157) lnk_ne_next = (b != 8'd0);
                        if (o < 10'd100) flg_next = path_feed(flg_next, b, o == 10'd99);
                        if (o == 10'd345) begin
                            flg_next[5:3] = 3'd0;
                            if (b != 8'd0) flg_next[6] = 1'b1;
                            if (b == 8'd47) flg_next[7] = 1'b1;
                        end
                        if (o >= 10'd345 && o < 10'd500)
                            flg_next = path_feed(flg_next, b, o == 10'd499);
                        ofs_next = ofs_reg + 1'b1;
                        if (o == 10'(BLOCK_BYTES - 1)) begin
                            // verdict on the completed block
                            emit = 1'b1;
                            if (zero_next) begin
                                phase_next = PH_DONE;
                                res_next.kind = KIND_END;
                                res_next.status = memb_reg ? ST_OK : ST_NOMEMBERS;
                            end else begin
                                bad_name = flg_next[6] ? (flg_next[7] || flg_next[2])
                                         : (flg_next[0] || flg_next[1] || flg_next[2]);
                                t = (type_next == 8'd0) ? 8'd48 : type_next;
                                if (oct_next[5:4] == OCT_FAIL || {7'd0, sum_next} != chk_next)
                                    st = ST_CHECKSUM;
                                else if (bad_name)
                                    st = ST_NAME;
                                else if (oct_next[1:0] == OCT_FAIL || oct_next[3:2] == OCT_FAIL
                                         || mode_next > 24'o7777)
                                    st = ST_SIZEMODE;
                                else if (t == 8'd48) begin
                                    mt = MT_REG;
                                    if (link_reg) st = ST_AFTERLINK;
                                end else if (t == 8'd53) begin
                                    mt = MT_DIR;
                                    if (link_reg) st = ST_AFTERLINK;
                                end else if (t == 8'd50) begin
                                    mt = MT_LINK;
                                    link_next = 1'b1;
                                    if (size_next != '0) st = ST_LINKDATA;
                                    else if (!lnk_ne_next) st = ST_LINKEMPTY;
                                end else
                                    st = ST_TYPE;
                                res_next.kind = KIND_VERDICT;
                                res_next.status = st;
                                if (st != ST_OK)
                                    phase_next = PH_ERROR;
                                else begin
                                    memb_next = 1'b1;
                                    rem_next = size_next;
                                    pad_next = OFS_W'(0) - size_next[OFS_W-1:0];
                                    if (size_next != '0)
                                        phase_next = (mt == MT_REG) ? PH_PAYLOAD : PH_SKIP;
                                    res_next.mtype = mt;
                                    res_next.size = size_next;
                                    res_next.mode = mode_next[11:0];
                                end
                            end
                        end
                    end
                    PH_PAYLOAD, PH_SKIP:
                    begin
                        rem_next = rm1;
                        if (phase_reg == PH_PAYLOAD) begin
                            emit = 1'b1;
                            res_next.kind = KIND_PAYLOAD;
                            res_next.pbyte = b;
                            res_next.last = (rm1 == '0);
                        end
                        if (rm1 == '0)
                            phase_next = (pad_reg != '0) ? PH_PAD : PH_HEADER;
                    end
                    default:
                    begin
                        pad_next = pad_reg - 1'b1;
                        if (pad_next == '0) phase_next = PH_HEADER;
                    end
                endcase
            end
        end
        if (emit) ov_next = 1'b1;
        else if (!ov_next) res_next = res_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            ofs_reg <= '0; phase_reg <= PH_HEADER; sum_reg <= '0; zero_reg <= 1'b1;
            size_reg <= '0; mode_reg <= '0; chk_reg <= '0; oct_reg <= '0;
            type_reg <= '0; flg_reg <= '0; rem_reg <= '0; pad_reg <= '0;
            link_reg <= 1'b0; memb_reg <= 1'b0; lnk_ne_reg <= 1'b0; ov_reg <= 1'b0;
        end else begin
            ofs_reg <= ofs_next; phase_reg <= phase_next; sum_reg <= sum_next;
            zero_reg <= zero_next; size_reg <= size_next; mode_reg <= mode_next;
            chk_reg <= chk_next; oct_reg <= oct_next; type_reg <= type_next;
            flg_reg <= flg_next; rem_reg <= rem_next; pad_reg <= pad_next;
            link_reg <= link_next; memb_reg <= memb_next; lnk_ne_reg <= lnk_ne_next;
            ov_reg <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    // a held result must not change while stalled
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(res_reg))
        else $error("result changed under stall");
    // once finished or failed, no new beat produces a result
    a_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_DONE || phase_reg == PH_ERROR) |=> !emit)
        else $error("result after archive end");
    // payload only while in the payload phase
    a_pay: assert property (@(posedge clk) disable iff (!rst_n)
        emit && res_next.kind == KIND_PAYLOAD |-> phase_reg == PH_PAYLOAD)
        else $error("payload outside payload phase");
endmodule
`default_nettype wire
